@@ hw/rtl/float_to_pcm_bytes_defines.svh @@
// Assertion macros shared by the RTL files.
`ifndef FLOAT_TO_PCM_BYTES_DEFINES_SVH
`define FLOAT_TO_PCM_BYTES_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define F2P_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define F2P_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/f2p_pkg.sv @@
package f2p_pkg;

    localparam int unsigned WordW = 32;

    typedef enum logic [1:0] {
        WCODE_16 = 2'd0,
        WCODE_24 = 2'd1,
        WCODE_8  = 2'd2,
        WCODE_32 = 2'd3
    } wcode_t;

    typedef enum logic [1:0] {
        REG_WIDTH    = 2'd0,
        REG_UNSIGNED = 2'd1,
        REG_FLOAT    = 2'd2,
        REG_ENDIAN   = 2'd3
    } reg_idx_t;

    // One encoded sample passed from the encoder to the serializer.
    typedef struct packed {
        logic [WordW-1:0] word;
        logic [1:0]       last_idx;   // number of bytes minus one
        logic             big;
        logic             clip;
    } enc_t;

    function automatic logic [1:0] last_idx_of(input wcode_t c);
        logic [1:0] r;
        begin
            unique case (c)
                WCODE_16: r = 2'd1;
                WCODE_24: r = 2'd2;
                WCODE_8:  r = 2'd0;
                default:  r = 2'd3;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/f2p_encode.sv @@
module f2p_encode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       sample_bits,
    input  f2p_pkg::wcode_t   wcode,
    input  logic              uns,
    input  logic              flt,
    input  logic              big,
    output logic              enc_valid,
    input  logic              enc_ready,
    output f2p_pkg::enc_t     enc
);

    // Stage 1: shift the mantissa. Stage 2: round, saturate, offset.
    logic        s1_valid_reg;
    logic        s1_sign_reg;
    logic        s1_nan_reg;
    logic        s1_big_reg;     // magnitude saturates
    logic [32:0] s1_q_reg;
    logic        s1_rnd_reg;     // round up
    logic [1:0]  s1_lidx_reg;
    logic        s1_flt_reg;
    logic        s1_uns_reg;
    logic        s1_bigend_reg;
    logic [31:0] s1_raw_reg;

    logic          s2_valid_reg;
    f2p_pkg::enc_t s2_reg;

    logic adv2, adv1;
    assign adv2     = !s2_valid_reg || enc_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // Stage 1 logic
    logic [7:0]  ex;
    logic [23:0] m;
    logic [5:0]  n_bits;
    logic signed [9:0] sh;
    logic [7:0]  k;
    logic [63:0] mx;
    logic [32:0] q;
    logic        rnd, ovf;
    logic [23:0] rem, half;

    always_comb
    begin
        ex = sample_bits[30:23];
        m  = {(ex != 8'd0), sample_bits[22:0]};
        unique case (wcode)
            f2p_pkg::WCODE_16: n_bits = 6'd16;
            f2p_pkg::WCODE_24: n_bits = 6'd24;
            f2p_pkg::WCODE_8:  n_bits = 6'd8;
            default:           n_bits = 6'd32;
        endcase
        sh = $signed({2'b00, (ex != 8'd0) ? ex : 8'd1}) - 10'sd151
             + $signed({4'b0000, n_bits});
        q = '0; rnd = 1'b0; ovf = 1'b0; k = '0; mx = '0; rem = '0; half = '0;
        if (sh >= 0) begin
            // any left shift of a nonzero mantissa by more than 9 exceeds 33 bits
            if (sh > 10'sd9 && m != 24'd0) ovf = 1'b1;
            else begin
                mx = {40'd0, m} << sh[3:0];
                q  = mx[32:0];
            end
        end else begin
            k = 8'(-sh);
            if (k < 8'd25) begin
                q    = {9'd0, m >> k[4:0]};
                rem  = m & ((24'd1 << k[4:0]) - 24'd1);
                half = 24'd1 << (k[4:0] - 5'd1);
                rnd  = (rem > half) || (rem == half && q[0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else if (adv1) s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_sign_reg   <= sample_bits[31];
            s1_nan_reg    <= (ex == 8'hff) && (sample_bits[22:0] != 23'd0);
            s1_big_reg    <= ovf || (ex == 8'hff);
            s1_q_reg      <= q;
            s1_rnd_reg    <= rnd;
            s1_lidx_reg   <= flt ? 2'd3 : f2p_pkg::last_idx_of(wcode);
            s1_flt_reg    <= flt;
            s1_uns_reg    <= uns;
            s1_bigend_reg <= big;
            s1_raw_reg    <= sample_bits;
        end
    end

    // Stage 2 logic
    logic [33:0] mag;
    logic [32:0] lim_pos, lim_neg;
    logic [5:0]  nn;
    logic [31:0] val;
    logic        clip;

    always_comb
    begin
        nn      = {1'b0, s1_lidx_reg, 3'b111} + 6'd1;
        lim_neg = 33'd1 << (nn - 6'd1);
        lim_pos = lim_neg - 33'd1;
        mag     = {1'b0, s1_q_reg} + {33'd0, s1_rnd_reg};
        clip    = 1'b0;
        val     = '0;
        if (s1_nan_reg) clip = 1'b1;
        else if (s1_sign_reg) begin
            if (s1_big_reg || mag > {1'b0, lim_neg}) begin
                mag = {1'b0, lim_neg}; clip = 1'b1;
            end
            val = 32'(34'd0 - mag);
        end else begin
            if (s1_big_reg || mag > {1'b0, lim_pos}) begin
                mag = {1'b0, lim_pos}; clip = 1'b1;
            end
            val = mag[31:0];
        end
        val = val & 32'(lim_neg + lim_neg - 33'd1);
        if (s1_uns_reg) val = val ^ lim_neg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_valid_reg <= 1'b0;
        else if (adv2) s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_reg.word     <= s1_flt_reg ? s1_raw_reg : val;
            s2_reg.clip     <= s1_flt_reg ? 1'b0 : clip;
            s2_reg.last_idx <= s1_lidx_reg;
            s2_reg.big      <= s1_bigend_reg;
        end
    end

    assign enc_valid = s2_valid_reg;
    assign enc      = s2_reg;

endmodule

@@ hw/rtl/f2p_queue.sv @@
`include "float_to_pcm_bytes_defines.svh"
module f2p_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  f2p_pkg::enc_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output f2p_pkg::enc_t rd_data
);

    f2p_pkg::enc_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    `F2P_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg != 2'd3, "queue count out of range")
    `F2P_ASSERT_NEXT(a_full_hold, cnt_reg == 2'd2 && !rd, cnt_reg == 2'd2, "full queue lost entry")
    `F2P_ASSERT_IMP(a_ptrs, cnt_reg == 2'd0 || cnt_reg == 2'd2, wp_reg == rp_reg, "pointer mismatch")

endmodule

@@ hw/rtl/f2p_serial.sv @@
`include "float_to_pcm_bytes_defines.svh"
module f2p_serial (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  f2p_pkg::enc_t q_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_byte,
    output logic          m_last,
    output logic          m_clip
);

    logic [1:0] pos_reg;
    logic [1:0] idx;
    logic       last;

    assign last    = pos_reg == q_data.last_idx;
    assign idx     = q_data.big ? (q_data.last_idx - pos_reg) : pos_reg;
    assign m_valid = q_valid;
    assign m_byte  = q_data.word[{idx, 3'b000} +: 8];
    assign m_last  = last;
    assign m_clip  = q_data.clip;
    assign q_ready = m_ready && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pos_reg <= 2'd0;
        else if (q_valid && m_ready) pos_reg <= last ? 2'd0 : pos_reg + 2'd1;
    end

    `F2P_ASSERT_IMP(a_pos_bound, q_valid, pos_reg <= q_data.last_idx, "byte index past end")
    `F2P_ASSERT_NEXT(a_pos_reset, q_valid && m_ready && last, pos_reg == 2'd0, "index not cleared")
    `F2P_ASSERT_IMP(a_pos_idle, !q_valid, pos_reg == 2'd0, "index moved while idle")

endmodule

@@ hw/rtl/float_to_pcm_bytes.sv @@
// Channel   Dir  Payload
// s_axis    in   tdata[31:0] = sample_bits
// m_axis    out  tdata[7:0] = out_byte, tlast = last_byte, tuser[0] = clipped
// cfg       in   cfg_index selects width_code/unsigned_out/float_out/big_endian
//
// One byte leaves per cycle while m_axis_tready is high; a sample gives
// 1, 2, 3 or 4 bytes by format. Encoding is a two-stage pipeline ahead of
// a two-entry queue, so samples are taken while bytes still drain.
// A sample passes stage 1, stage 2 and the queue before its first byte.
// rst_n clears valid state and the format registers; stalls on m_axis back up
// through the queue to s_axis_tready.
module float_to_pcm_bytes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] sample_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,    // [0] clipped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    f2p_pkg::wcode_t wcode_reg;
    logic uns_reg, flt_reg, big_reg;

    assign cfg_ready = 1'b1;

    // hold the format registers; take each request at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcode_reg <= f2p_pkg::WCODE_16;
            uns_reg   <= 1'b0;
            flt_reg   <= 1'b0;
            big_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (f2p_pkg::reg_idx_t'(cfg_index))
                f2p_pkg::REG_WIDTH:    wcode_reg <= f2p_pkg::wcode_t'(cfg_data[1:0]);
                f2p_pkg::REG_UNSIGNED: uns_reg   <= cfg_data[0];
                f2p_pkg::REG_FLOAT:    flt_reg   <= cfg_data[0];
                default:               big_reg   <= cfg_data[0];
            endcase
        end
    end

    logic          e_valid, e_ready, q_valid, q_ready;
    f2p_pkg::enc_t e_data, q_data;

    f2p_encode u_enc (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .sample_bits(s_axis_tdata),
        .wcode(wcode_reg), .uns(uns_reg), .flt(flt_reg), .big(big_reg),
        .enc_valid(e_valid), .enc_ready(e_ready), .enc(e_data)
    );

    f2p_queue u_q (
        .clk, .rst_n,
        .wr_valid(e_valid), .wr_ready(e_ready), .wr_data(e_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    f2p_serial u_ser (
        .clk, .rst_n,
        .q_valid, .q_ready, .q_data,
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_byte(m_axis_tdata), .m_last(m_axis_tlast), .m_clip(m_axis_tuser)
    );

endmodule
